// ===== rtl/rpn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the registry path normalizer: limits, codes, state and result types.
// Used by every module of the block and by rpn_out_if; depends on nothing.
package rpn_pkg;

  // String length limits per mode
  localparam int KEY_MAX_BYTES  = 256;
  localparam int NAME_MAX_BYTES = 256;

  // Reported length saturates at this value
  localparam int LEN_W   = 9;
  localparam int LEN_CAP = (1 << LEN_W) - 1;

  // Internal byte count must hold more than either limit and the length cap
  localparam int MAX_BYTES = (KEY_MAX_BYTES > NAME_MAX_BYTES) ? KEY_MAX_BYTES : NAME_MAX_BYTES;
  localparam int CNT_LIM   = (MAX_BYTES > LEN_CAP) ? MAX_BYTES : LEN_CAP;
  localparam int CNT_W     = $clog2(CNT_LIM + 1) + 1;

  // Accepted root keys, first byte in the high byte
  localparam logic [31:0] ROOT_HKLM = 32'h484B_4C4D;
  localparam logic [31:0] ROOT_HKCU = 32'h484B_4355;
  localparam logic [31:0] ROOT_HKCR = 32'h484B_4352;
  localparam logic [31:0] ROOT_HKCC = 32'h484B_4343;
  localparam logic [31:0] ROOT_HKU  = 32'h0048_4B55;

  // Character codes
  localparam logic [7:0] CH_CTRL_END = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Mode register values
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_NAME = 1'b1;

  typedef enum logic [1:0] {
    VERD_OK       = 2'd0,
    VERD_BAD_KEY  = 2'd1,
    VERD_BAD_NAME = 2'd2
  } verdict_t;

  // One result item
  typedef struct packed {
    logic [7:0]       out_char;
    logic             done_res;
    verdict_t         verdict;
    logic [LEN_W-1:0] string_length;
  } result_t;

  // Running per-string state
  typedef struct packed {
    logic             error_seen;
    logic [CNT_W-1:0] byte_count;
    logic [1:0]       comp_len;
    logic             comp_all_dots;
    logic [31:0]      root_chars;
    logic [2:0]       root_len;
    logic             root_closed;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '{
    error_seen:    1'b0,
    byte_count:    '0,
    comp_len:      2'd0,
    comp_all_dots: 1'b1,
    root_chars:    32'h0,
    root_len:      3'd0,
    root_closed:   1'b0
  };

  // Map a-z to A-Z
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  // Characters forbidden under the given mode
  function automatic logic byte_is_bad(input logic [7:0] c, input logic mode);
    logic bad;
    bad = 1'b0;
    if (c < CH_CTRL_END || c >= CH_DEL) begin
      bad = 1'b1;
    end
    if (c inside {8'h2F, 8'h2A, 8'h3F, 8'h22, 8'h3C, 8'h3E, 8'h7C}) begin
      bad = 1'b1;
    end
    if (mode == MODE_KEY && c == CH_COLON) begin
      bad = 1'b1;
    end
    if (mode == MODE_NAME && c == CH_BSLASH) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

  // Component is "." or ".."
  function automatic logic comp_is_dot(input logic [1:0] len, input logic all_dots);
    return all_dots && (len == 2'd1 || len == 2'd2);
  endfunction

  function automatic logic root_ok(input logic [31:0] chars, input logic [2:0] len);
    logic ok;
    ok = 1'b0;
    if (len == 3'd4) begin
      ok = (chars == ROOT_HKLM) || (chars == ROOT_HKCU) ||
           (chars == ROOT_HKCR) || (chars == ROOT_HKCC);
    end else if (len == 3'd3) begin
      ok = (chars == ROOT_HKU);
    end
    return ok;
  endfunction

endpackage

// ===== rtl/rpn_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the registry path normalizer: at most one string byte per request.
// Self-contained; the byte and flag widths are fixed.
interface rpn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_last;
  logic       no_char;

  modport source (output valid, output in_char, output is_last, output no_char, input ready);
  modport sink   (input valid, input in_char, input is_last, input no_char, output ready);
endinterface

// ===== rtl/rpn_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the registry path normalizer: one result per input request.
// Widths follow rpn_pkg.
interface rpn_out_if
  import rpn_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [7:0]       out_char;
  logic             done_res;
  logic [1:0]       verdict;
  logic [LEN_W-1:0] string_length;

  modport source (output valid, output out_char, output done_res, output verdict,
                  output string_length, input ready);
  modport sink   (input valid, input out_char, input done_res, input verdict,
                  input string_length, output ready);
endinterface

// ===== rtl/registry_path_normalizer.sv =====
`timescale 1ns / 1ps
// Registry path normalizer: streams a key path or value name byte by byte,
// upper-cases a-z and checks the string, giving a verdict on its last byte.
//
// Channels: in_ch carries one byte request (in_char, is_last, no_char);
// out_ch returns one result per request: the upper-cased byte, done_res, and
// on the last request the verdict and the string length. cfg_we/cfg_wdata
// write the mode bit (0 key path, 1 value name); write it between strings.
// Each result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the per-byte checks and the running
// string state update sit between the input port and one result register.
// A new request is taken while a result waits, as long as that result is
// taken in the same cycle; when the receiver stalls, in_ch.ready drops and
// the held result stays put.
// Reset: synchronous, active low; clears the mode to key path, the string
// state and the result valid flag. Ready is high from the first cycle after.
// Depends on rpn_pkg, rpn_in_if, rpn_out_if, rpn_scan and rpn_out_reg.
module registry_path_normalizer
  import rpn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  logic    name_mode_r;
  logic    free;
  logic    take;
  result_t res;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_mode_r <= MODE_KEY;
    end else if (cfg_we) begin
      name_mode_r <= cfg_wdata;
    end
  end

  // Accept a request when the result register can take its result
  assign in_ch.ready = free;
  assign take        = in_ch.valid && free;

  rpn_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .name_mode (name_mode_r),
    .in_char   (in_ch.in_char),
    .is_last   (in_ch.is_last),
    .no_char   (in_ch.no_char),
    .res       (res)
  );

  rpn_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take),
    .res    (res),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/rpn_scan.sv =====
`timescale 1ns / 1ps
// Running string state and the single-pass check of one byte.
// Depends on rpn_pkg for the state and result types and character tests.
module rpn_scan
  import rpn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       name_mode,
  input  logic [7:0] in_char,
  input  logic       is_last,
  input  logic       no_char,
  output result_t    res
);

  scan_state_t st_r, st_nxt;
  scan_state_t upd;
  logic [7:0]  up;
  logic        bad_end;

  // Fold one byte into the state and form the result
  always_comb begin
    up  = to_upper(in_char);
    upd = st_r;
    if (!no_char) begin
      if (st_r.byte_count != '1) begin
        upd.byte_count = st_r.byte_count + 1'b1;
      end
      if (byte_is_bad(in_char, name_mode)) begin
        upd.error_seen = 1'b1;
      end
      if (name_mode == MODE_KEY && in_char == CH_BSLASH) begin
        // close the component
        if (st_r.comp_len == 2'd0 || comp_is_dot(st_r.comp_len, st_r.comp_all_dots)) begin
          upd.error_seen = 1'b1;
        end
        upd.root_closed   = 1'b1;
        upd.comp_len      = 2'd0;
        upd.comp_all_dots = 1'b1;
      end else begin
        if (st_r.comp_len != 2'd3) begin
          upd.comp_len = st_r.comp_len + 2'd1;
        end
        if (up != CH_DOT) begin
          upd.comp_all_dots = 1'b0;
        end
        if (!st_r.root_closed) begin
          if (st_r.root_len < 3'd4) begin
            upd.root_chars = {st_r.root_chars[23:0], up};
          end
          if (st_r.root_len < 3'd5) begin
            upd.root_len = st_r.root_len + 3'd1;
          end
        end
      end
    end

    // End-of-string checks under the current mode
    bad_end = upd.error_seen;
    if (name_mode == MODE_KEY) begin
      if (upd.byte_count > CNT_W'(KEY_MAX_BYTES)) bad_end = 1'b1;
      if (upd.byte_count == '0 || upd.comp_len == 2'd0) bad_end = 1'b1;
      if (comp_is_dot(upd.comp_len, upd.comp_all_dots)) bad_end = 1'b1;
      if (!root_ok(upd.root_chars, upd.root_len)) bad_end = 1'b1;
    end else begin
      if (upd.byte_count > CNT_W'(NAME_MAX_BYTES)) bad_end = 1'b1;
      if (upd.byte_count != '0 && comp_is_dot(upd.comp_len, upd.comp_all_dots)) begin
        bad_end = 1'b1;
      end
    end

    res.out_char      = no_char ? 8'h00 : up;
    res.done_res      = is_last;
    res.verdict       = VERD_OK;
    res.string_length = '0;
    if (is_last) begin
      if (bad_end) begin
        res.verdict = (name_mode == MODE_KEY) ? VERD_BAD_KEY : VERD_BAD_NAME;
      end
      res.string_length = (upd.byte_count > CNT_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                             : upd.byte_count[LEN_W-1:0];
    end

    // Clear after the last byte, hold when idle
    st_nxt = st_r;
    if (take) begin
      st_nxt = is_last ? SCAN_CLEAR : upd;
    end
  end

  // Hold the running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/rpn_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the registry path normalizer, drives the result channel.
// Depends on rpn_pkg for result_t and on rpn_out_if.
module rpn_out_reg
  import rpn_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  result_t      res,
  output logic         free,
  rpn_out_if.source    out_ch
);

  logic    valid_r, valid_nxt;
  result_t data_r, data_nxt;

  // Free when empty or when the held result leaves this cycle
  assign free = !valid_r || out_ch.ready;

  // Load a new result or drop the delivered one
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.out_char      = data_r.out_char;
  assign out_ch.done_res      = data_r.done_res;
  assign out_ch.verdict       = data_r.verdict;
  assign out_ch.string_length = data_r.string_length;

endmodule
